[sv/petg_pkg.sv]
package petg_pkg;

  localparam int TIME_W   = 48;
  localparam int ENERGY_W = 24;
  localparam int ROW_W    = 32;
  localparam int GAP_W    = 16;
  localparam int WIDE_W   = GAP_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  localparam logic KIND_HIT   = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRADE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_CAP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AFTER_0 = 3'd2;
  localparam int                   REG_PAIR_STRIDE = 2;

  localparam logic [1:0] CLASS_NONE = 2'd3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic                used;
    logic                prev_known;
    logic [TIME_W-1:0]   cur_time;
    logic [WIDE_W-1:0]   before_whole;
    logic                before_frac;
    logic [ENERGY_W-1:0] energy;
    logic [ROW_W-1:0]    row;
  } entry_t;

  typedef struct packed {
    logic                err;
    logic                pile;
    logic [1:0]          grade_class;
    logic [ENERGY_W-1:0] energy;
    logic [GAP_W-1:0]    prior;
    logic [WIDE_W-1:0]   after;
    logic [ROW_W-1:0]    row;
  } result_t;

  function automatic logic [GAP_W-1:0] cap_gap(input logic [WIDE_W-1:0] whole,
                                               input logic frac,
                                               input logic [GAP_W-1:0] cap);
    logic over;
    over = (whole > {1'b0, cap}) || ((whole == {1'b0, cap}) && frac);
    return over ? cap : whole[GAP_W-1:0];
  endfunction

endpackage

[sv/pixel_event_time_grading.sv]
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser kind; tdata pixel, time, energy, row
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser flags; tdata row, gaps, energy, class
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i register index, cfg_data_i value
//
// One item per cycle while s_axis_tready is high; a result passes the S1 and S2
// registers and the result queue before it is offered on m_axis.
// The per-pixel read-modify-write of the state memory sets the rate, with the
// write of one item forwarded to the read of the next.
// After reset a clearing pass writes all PIXELS entries; s_axis_tready stays low meanwhile.
// A four-entry result queue with credit keeps input flowing while m_axis stalls, until it is full.
module pixel_event_time_grading import petg_pkg::*; #(
  parameter int PIXELS     = 1024,
  parameter int FRAC_BITS  = 16,
  parameter int MAX_GRADES = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [9:0] pixel_id, [57:10] event_time, [81:58] energy, [113:82] row_tag
  input  logic [119:0]         s_axis_tdata,
  // [0] kind
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] graded_row, [48:32] grade_after, [64:49] grade_before,
  // [88:65] total_energy, [90:89] grade_class
  output logic [95:0]          m_axis_tdata,
  // [0] is_pileup, [1] is_error
  output logic [1:0]           m_axis_tuser,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GAP_W-1:0]     cfg_data_i
);

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [TIME_W-1:0] FRAC_MASK = (TIME_W'(1) << FRAC_BITS) - TIME_W'(1);

  typedef enum logic [1:0] {
    MODE_NORM,
    MODE_PILE,
    MODE_ERR,
    MODE_FLUSH
  } mode_e;

  // configuration
  logic [1:0]       grade_count_q;
  logic [GAP_W-1:0] gap_cap_q;
  logic [GAP_W-1:0] min_after_q  [MAX_GRADES];
  logic [GAP_W-1:0] min_before_q [MAX_GRADES];
  logic             cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grade_count_q <= 2'd3;
      gap_cap_q     <= 16'd32768;
      for (int k = 0; k < MAX_GRADES; k++) begin
        min_after_q[k]  <= '0;
        min_before_q[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index_i == REG_GRADE_COUNT) grade_count_q <= cfg_data_i[1:0];
      if (cfg_index_i == REG_GAP_CAP) gap_cap_q <= cfg_data_i;
      for (int k = 0; k < MAX_GRADES; k++) begin
        if (cfg_index_i == CFG_IDX_W'(REG_MIN_AFTER_0 + REG_PAIR_STRIDE * k))
          min_after_q[k] <= cfg_data_i;
        if (cfg_index_i == CFG_IDX_W'(REG_MIN_AFTER_0 + REG_PAIR_STRIDE * k + 1))
          min_before_q[k] <= cfg_data_i;
      end
    end
  end

  // input decode
  logic                s_fire;
  logic [9:0]          in_pixel;
  logic [TIME_W-1:0]   in_time;
  logic [ENERGY_W-1:0] in_energy;
  logic [ROW_W-1:0]    in_row;
  logic [12:0]         in_pixel_x;
  logic                in_range;
  logic [AW-1:0]       rd_addr;
  logic                rd_en;

  assign in_pixel   = s_axis_tdata[9:0];
  assign in_time    = s_axis_tdata[57:10];
  assign in_energy  = s_axis_tdata[81:58];
  assign in_row     = s_axis_tdata[113:82];
  assign in_pixel_x = 13'(in_pixel);
  assign in_range   = in_pixel_x < 13'(PIXELS);
  assign rd_addr    = in_pixel_x[AW-1:0];
  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign rd_en      = s_fire && in_range;

  // state memory
  entry_t        mem_q [PIXELS];
  entry_t        rdata_q;
  entry_t        fwd_data_q;
  logic          fwd_hit_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
    fwd_data_q <= wr_data;
  end

  // S1 item registers
  logic                s1_v_q;
  logic                s1_kind_q;
  logic [AW-1:0]       s1_addr_q;
  logic [TIME_W-1:0]   s1_time_q;
  logic [ENERGY_W-1:0] s1_energy_q;
  logic [ROW_W-1:0]    s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      s1_v_q     <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(PIXELS - 1)) clr_busy_q <= 1'b0;
      end
      s1_v_q    <= rd_en;
      fwd_hit_q <= rd_en && wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_kind_q   <= s_axis_tuser;
    s1_addr_q   <= rd_addr;
    s1_time_q   <= in_time;
    s1_energy_q <= in_energy;
    s1_row_q    <= in_row;
  end

  // S1: gap after, state update
  entry_t              ent;
  entry_t              s1_wdata;
  logic                s1_we;
  logic [TIME_W:0]     diff;
  logic                a_neg;
  logic [TIME_W-1:0]   a_whole_full;
  logic [WIDE_W-1:0]   a_whole;
  logic                a_frac;
  logic                a_zero;
  logic [ENERGY_W:0]   e_sum;
  logic [ENERGY_W-1:0] e_sat;
  logic                s1_res;
  mode_e               s1_mode;

  always_comb begin
    ent          = fwd_hit_q ? fwd_data_q : rdata_q;
    diff         = {1'b0, s1_time_q} - {1'b0, ent.cur_time};
    a_neg        = diff[TIME_W];
    a_whole_full = diff[TIME_W-1:0] >> FRAC_BITS;
    a_whole      = (|a_whole_full[TIME_W-1:WIDE_W]) ? '1 : a_whole_full[WIDE_W-1:0];
    a_frac       = |(diff[TIME_W-1:0] & FRAC_MASK);
    a_zero       = (gap_cap_q == '0) || (a_whole_full == '0);
    e_sum        = {1'b0, ent.energy} + {1'b0, s1_energy_q};
    e_sat        = e_sum[ENERGY_W] ? ENERGY_MAX : e_sum[ENERGY_W-1:0];
    s1_res       = s1_v_q && ent.used;
    s1_we        = s1_v_q && ((s1_kind_q != KIND_FLUSH) || ent.used);
    s1_wdata     = ent;
    s1_mode      = MODE_NORM;
    if (s1_kind_q == KIND_FLUSH) begin
      s1_mode             = MODE_FLUSH;
      s1_wdata.used       = 1'b0;
      s1_wdata.prev_known = 1'b0;
    end else if (!ent.used) begin
      s1_wdata.used       = 1'b1;
      s1_wdata.prev_known = 1'b0;
      s1_wdata.cur_time   = s1_time_q;
      s1_wdata.energy     = s1_energy_q;
      s1_wdata.row        = s1_row_q;
    end else if (a_neg) begin
      s1_mode             = MODE_ERR;
      s1_wdata.prev_known = 1'b0;
      s1_wdata.cur_time   = s1_time_q;
      s1_wdata.energy     = s1_energy_q;
      s1_wdata.row        = s1_row_q;
    end else if (a_zero) begin
      s1_mode         = MODE_PILE;
      s1_wdata.energy = e_sat;
      s1_wdata.row    = s1_row_q;
    end else begin
      s1_wdata.prev_known   = 1'b1;
      s1_wdata.before_whole = a_whole;
      s1_wdata.before_frac  = a_frac;
      s1_wdata.cur_time     = s1_time_q;
      s1_wdata.energy       = s1_energy_q;
      s1_wdata.row          = s1_row_q;
    end
  end

  assign wr_en   = clr_busy_q || s1_we;
  assign wr_addr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign wr_data = clr_busy_q ? entry_t'('0) : s1_wdata;

  // S2 registers
  logic                s2_v_q;
  mode_e               s2_mode_q;
  logic [ROW_W-1:0]    s2_row_q;
  logic [ENERGY_W-1:0] s2_energy_q;
  logic                s2_a_neg_q;
  logic [WIDE_W-1:0]   s2_a_whole_q;
  logic                s2_a_frac_q;
  logic                s2_b_known_q;
  logic [WIDE_W-1:0]   s2_b_whole_q;
  logic                s2_b_frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_res;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_mode_q    <= s1_mode;
    s2_row_q     <= ent.row;
    s2_energy_q  <= (s1_mode == MODE_PILE) ? '0 : ent.energy;
    s2_a_neg_q   <= a_neg;
    s2_a_whole_q <= a_whole;
    s2_a_frac_q  <= a_frac;
    s2_b_known_q <= ent.prev_known;
    s2_b_whole_q <= ent.before_whole;
    s2_b_frac_q  <= ent.before_frac;
  end

  // S2: capping and class
  logic [GAP_W-1:0] ga;
  logic [GAP_W-1:0] gb;
  logic [GAP_W-1:0] ga_sel;
  logic [1:0]       n_lim;
  logic [1:0]       cls;
  result_t          s2_res;

  always_comb begin
    ga     = s2_a_neg_q ? '0 : cap_gap(s2_a_whole_q, s2_a_frac_q, gap_cap_q);
    gb     = s2_b_known_q ? cap_gap(s2_b_whole_q, s2_b_frac_q, gap_cap_q) : gap_cap_q;
    ga_sel = (s2_mode_q == MODE_FLUSH) ? gap_cap_q : ga;
    n_lim  = (grade_count_q > 2'(MAX_GRADES)) ? 2'(MAX_GRADES) : grade_count_q;
    cls    = CLASS_NONE;
    for (int i = MAX_GRADES - 1; i >= 0; i--) begin
      if ((2'(i) < n_lim) && (ga_sel >= min_after_q[i]) && (gb >= min_before_q[i]))
        cls = 2'(i);
    end
    s2_res.row    = s2_row_q;
    s2_res.prior  = gb;
    s2_res.energy = s2_energy_q;
    s2_res.pile   = 1'b0;
    s2_res.err    = 1'b0;
    unique case (s2_mode_q)
      MODE_FLUSH: begin
        s2_res.after       = {1'b0, gap_cap_q};
        s2_res.grade_class = cls;
      end
      MODE_PILE: begin
        s2_res.after       = '1;
        s2_res.grade_class = CLASS_NONE;
        s2_res.pile        = 1'b1;
      end
      MODE_ERR: begin
        s2_res.after       = {1'b0, ga};
        s2_res.grade_class = CLASS_NONE;
        s2_res.err         = 1'b1;
      end
      default: begin
        s2_res.after       = {1'b0, ga};
        s2_res.grade_class = cls;
      end
    endcase
  end

  // result queue
  result_t            fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q;
  logic [FIFO_AW-1:0] rd_ptr_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic               m_fire;
  logic [FIFO_CW-1:0] committed;
  result_t            head;

  assign m_fire    = m_axis_tvalid && m_axis_tready;
  assign committed = cnt_q + FIFO_CW'(s1_v_q) + FIFO_CW'(s2_v_q);
  assign s_axis_tready = !clr_busy_q && (committed < FIFO_CW'(FIFO_DEPTH));

  always_ff @(posedge clk_i) begin
    if (s2_v_q) fifo_q[wr_ptr_q] <= s2_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (s2_v_q) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      if (m_fire) rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      cnt_q <= cnt_q + FIFO_CW'(s2_v_q) - FIFO_CW'(m_fire);
    end
  end

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = {5'b0, head.grade_class, head.energy, head.prior,
                          head.after, head.row};
  assign m_axis_tuser  = {head.err, head.pile};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> cnt_q < FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_fire)
    else $error("item taken during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_v_q && $past(wr_en))
    else $error("forward without a pending read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> $past(s1_v_q))
    else $error("result without an item");

endmodule
